FILE: sv/thick_line_quad_expand_top_macros.svh
// ---------------------------------------------------------------------------
// thick line quad expand assertion macros
// shared concurrent check forms, clocked on aclk and quiet during reset
// ---------------------------------------------------------------------------
`ifndef THICK_LINE_QUAD_EXPAND_TOP_MACROS_SVH
`define THICK_LINE_QUAD_EXPAND_TOP_MACROS_SVH

// same-cycle implication
`define TLQE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLQE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tlqe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlqe_pkg
// widths, constants and helpers for the thick line quad expander
// ---------------------------------------------------------------------------
package tlqe_pkg;

    localparam int COORD_BITS = 24;
    localparam int THICK_BITS = 21;
    localparam int DIFF_W     = COORD_BITS + 1;        // endpoint difference
    localparam int MAG_W      = DIFF_W;                // |difference|
    localparam int TA_W       = THICK_BITS;            // |thickness|
    localparam int SQ_W       = 2 * MAG_W;             // squares and length squared
    localparam int TA2_W      = 2 * TA_W;              // thickness squared
    localparam int SPLIT      = MAG_W;                 // partial product cut
    localparam int PP_W       = TA2_W + SPLIT;
    localparam int NUM_W      = TA2_W + SQ_W;          // dividend
    localparam int QUO_W      = TA2_W - 1;             // quotient never reaches 2^41
    localparam int ROOT_W     = (QUO_W + 1) / 2;
    localparam int SQR_W      = 2 * ROOT_W + 1;        // root remainder and trial
    localparam int N_W        = ROOT_W + 1;            // signed normal component
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int SUB_LAT    = QUO_W + 1 + ROOT_W;    // divide and root stages
    localparam int N_MAX      = 1 << (THICK_BITS - 2);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // words carried alongside the divide and root pipeline
    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        logic   nx_neg;
        logic   ny_neg;
        logic   zero;
    } side_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return hi[COORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

FILE: sv/tlqe_div_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tlqe_div_sqrt
// pipelined floor(num / den) then integer square root, one bit per stage
// ---------------------------------------------------------------------------
module tlqe_div_sqrt import tlqe_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [SQ_W-1:0]   den,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0]   div_rem_reg [QUO_W+1];
    logic [QUO_W-1:0]  div_lq_reg  [QUO_W+1];
    logic [SQ_W-1:0]   div_den_reg [QUO_W+1];
    logic [SQR_W-1:0]  sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];

    // quotient is below 2^QUO_W, so the top part of num starts below den
    always_ff @(posedge aclk) begin
        if (en) begin
            div_rem_reg[0] <= num[QUO_W+SQ_W-1:QUO_W];
            div_lq_reg[0]  <= num[QUO_W-1:0];
            div_den_reg[0] <= den;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++) begin : g_div
            logic [SQ_W:0]   trial;
            logic [SQ_W:0]   diff;
            logic [SQ_W-1:0] rem_next;
            logic            bit_next;
            always_comb begin
                trial    = {div_rem_reg[j], div_lq_reg[j][QUO_W-1]};
                diff     = trial - {1'b0, div_den_reg[j]};
                bit_next = (trial >= {1'b0, div_den_reg[j]});
                rem_next = bit_next ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    div_rem_reg[j+1] <= rem_next;
                    div_lq_reg[j+1]  <= {div_lq_reg[j][QUO_W-2:0], bit_next};
                    div_den_reg[j+1] <= div_den_reg[j];
                end
            end
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++) begin : g_sqrt
            localparam int B = ROOT_W - 1 - i;
            logic [SQR_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SQR_W-1:0]  trial;
            logic              take;
            always_comb begin
                if (i == 0) begin
                    rem_in  = SQR_W'(div_lq_reg[QUO_W]);
                    root_in = '0;
                end else begin
                    rem_in  = sq_rem_reg[(i == 0) ? 0 : i-1];
                    root_in = sq_root_reg[(i == 0) ? 0 : i-1];
                end
                trial = (SQR_W'(root_in) << (B + 1)) | (SQR_W'(1) << (2 * B));
                take  = (rem_in >= trial);
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sq_rem_reg[i]  <= take ? (rem_in - trial) : rem_in;
                    sq_root_reg[i] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
                end
            end
        end
    endgenerate

    assign root = sq_root_reg[ROOT_W-1];

endmodule

FILE: sv/thick_line_quad_expand_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thick_line_quad_expand_top
// expands a line segment into the four corners of a thick quad and their box
// ---------------------------------------------------------------------------
//  channel   dir  width  content
//  s_axis    in   96     start_x, start_y, end_x, end_y (24 bit signed each)
//  m_axis    out  288    corners 0..3 x/y, box min x/y, box max x/y
//  cfg       in   21     line_thickness, signed
//
//  one word per cycle in and out while m_tready does not stall the pipe
//  the bulk of the pipe is the restoring divider (41 stages) and root (21 stages)
//  aresetn is synchronous active low and clears valid bits and thickness
//  the whole pipe advances together; a stall at m_tready freezes every stage
//  s_tready is high whenever the output register is empty or being taken
// ---------------------------------------------------------------------------
`include "thick_line_quad_expand_top_macros.svh"

module thick_line_quad_expand_top import tlqe_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wen,
    input  logic [THICK_BITS-1:0]     cfg_wdata,      // line_thickness
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [4*COORD_BITS-1:0]   s_tdata,        // start_x, start_y, end_x, end_y
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [12*COORD_BITS-1:0]  m_tdata         // c0 x,y  c1 x,y  c2 x,y  c3 x,y
                                                      // box_min x,y  box_max x,y
);

    // thickness register
    logic signed [THICK_BITS-1:0] thick_reg;

    // whole-pipe advance
    logic en;

    // stage 1: endpoints and differences
    logic                      p1_v_reg;
    coord_t                    p1_sx_reg, p1_sy_reg, p1_ex_reg, p1_ey_reg;
    logic signed [DIFF_W-1:0]  p1_dx_reg, p1_dy_reg;

    // stage 2: squares
    logic                      p2_v_reg;
    side_t                     p2_side_reg;
    logic [SQ_W-1:0]           p2_ax2_reg, p2_ay2_reg;
    logic [TA2_W-1:0]          p2_ta2_reg;
    logic [MAG_W-1:0]          ax, ay;
    logic [TA_W-1:0]           ta;
    side_t                     p2_side_next;

    // stage 3: length squared and partial products
    logic                      p3_v_reg;
    side_t                     p3_side_reg;
    logic [SQ_W-1:0]           p3_len2_reg;
    logic [PP_W-1:0]           p3_xl_reg, p3_xh_reg, p3_yl_reg, p3_yh_reg;
    logic [NUM_W-1:0]          num_x, num_y;

    // words riding alongside divide and root
    logic                      line_v_reg    [SUB_LAT];
    side_t                     line_side_reg [SUB_LAT];
    logic [ROOT_W-1:0]         root_x, root_y;

    // stage 4: signed normal
    logic                      p4_v_reg;
    side_t                     p4_side_reg;
    logic signed [N_W-1:0]     p4_nx_reg, p4_ny_reg;
    logic [N_W-1:0]            mx_w, my_w;
    logic [ROOT_W-1:0]         mx, my;

    // stage 5: saturated corners
    logic                      p5_v_reg;
    point_t                    p5_c_reg [4];

    // stage 6: pairwise box
    logic                      p6_v_reg;
    point_t                    p6_c_reg [4];
    point_t                    p6_lo01_reg, p6_hi01_reg, p6_lo23_reg, p6_hi23_reg;

    // stage 7: output register
    logic                      out_v_reg;
    point_t                    out_c_reg [4];
    point_t                    out_lo_reg, out_hi_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thick_reg <= '0;
        end else if (cfg_wen) begin
            thick_reg <= cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            p6_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k < SUB_LAT; k++) begin
                line_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            p1_v_reg      <= s_tvalid;
            p2_v_reg      <= p1_v_reg;
            p3_v_reg      <= p2_v_reg;
            line_v_reg[0] <= p3_v_reg;
            for (int k = 1; k < SUB_LAT; k++) begin
                line_v_reg[k] <= line_v_reg[k-1];
            end
            p4_v_reg  <= line_v_reg[SUB_LAT-1];
            p5_v_reg  <= p4_v_reg;
            p6_v_reg  <= p5_v_reg;
            out_v_reg <= p6_v_reg;
        end
    end

    // stage 1: d = start - end
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sx_reg <= s_tdata[0*COORD_BITS +: COORD_BITS];
            p1_sy_reg <= s_tdata[1*COORD_BITS +: COORD_BITS];
            p1_ex_reg <= s_tdata[2*COORD_BITS +: COORD_BITS];
            p1_ey_reg <= s_tdata[3*COORD_BITS +: COORD_BITS];
            p1_dx_reg <= DIFF_W'($signed(s_tdata[0*COORD_BITS +: COORD_BITS]))
                       - DIFF_W'($signed(s_tdata[2*COORD_BITS +: COORD_BITS]));
            p1_dy_reg <= DIFF_W'($signed(s_tdata[1*COORD_BITS +: COORD_BITS]))
                       - DIFF_W'($signed(s_tdata[3*COORD_BITS +: COORD_BITS]));
        end
    end

    // stage 2: magnitudes, squares and the sign of each normal component
    always_comb begin
        ax = p1_dx_reg[DIFF_W-1] ? MAG_W'(-p1_dx_reg) : MAG_W'(p1_dx_reg);
        ay = p1_dy_reg[DIFF_W-1] ? MAG_W'(-p1_dy_reg) : MAG_W'(p1_dy_reg);
        ta = thick_reg[THICK_BITS-1] ? TA_W'(-thick_reg) : TA_W'(thick_reg);
        p2_side_next.sx     = p1_sx_reg;
        p2_side_next.sy     = p1_sy_reg;
        p2_side_next.ex     = p1_ex_reg;
        p2_side_next.ey     = p1_ey_reg;
        p2_side_next.nx_neg = p1_dy_reg[DIFF_W-1] ^ thick_reg[THICK_BITS-1];
        p2_side_next.ny_neg = !(p1_dx_reg[DIFF_W-1] ^ thick_reg[THICK_BITS-1]);
        // thin line or degenerate segment gives no offset
        p2_side_next.zero   = (thick_reg == '0) || ((p1_dx_reg == '0) && (p1_dy_reg == '0));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_side_reg <= p2_side_next;
            p2_ax2_reg  <= SQ_W'(ax) * SQ_W'(ax);
            p2_ay2_reg  <= SQ_W'(ay) * SQ_W'(ay);
            p2_ta2_reg  <= TA2_W'(ta) * TA2_W'(ta);
        end
    end

    // stage 3: |d|^2 and t^2 * along^2 cut into two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            p3_side_reg <= p2_side_reg;
            p3_len2_reg <= p2_ax2_reg + p2_ay2_reg;
            p3_xl_reg   <= PP_W'(p2_ta2_reg) * PP_W'(p2_ay2_reg[SPLIT-1:0]);
            p3_xh_reg   <= PP_W'(p2_ta2_reg) * PP_W'(p2_ay2_reg[SQ_W-1:SPLIT]);
            p3_yl_reg   <= PP_W'(p2_ta2_reg) * PP_W'(p2_ax2_reg[SPLIT-1:0]);
            p3_yh_reg   <= PP_W'(p2_ta2_reg) * PP_W'(p2_ax2_reg[SQ_W-1:SPLIT]);
        end
    end

    assign num_x = (NUM_W'(p3_xh_reg) << SPLIT) + NUM_W'(p3_xl_reg);
    assign num_y = (NUM_W'(p3_yh_reg) << SPLIT) + NUM_W'(p3_yl_reg);

    // floor(t^2 along^2 / |d|^2), then its root; half of (root + 1) is the
    // normal component rounded to nearest
    tlqe_div_sqrt u_norm_x (
        .aclk (aclk),
        .en   (en),
        .num  (num_x),
        .den  (p3_len2_reg),
        .root (root_x)
    );

    tlqe_div_sqrt u_norm_y (
        .aclk (aclk),
        .en   (en),
        .num  (num_y),
        .den  (p3_len2_reg),
        .root (root_y)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            line_side_reg[0] <= p3_side_reg;
            for (int k = 1; k < SUB_LAT; k++) begin
                line_side_reg[k] <= line_side_reg[k-1];
            end
        end
    end

    // stage 4: rounded magnitude with sign
    always_comb begin
        mx_w = N_W'(root_x) + N_W'(1);
        my_w = N_W'(root_y) + N_W'(1);
        mx   = mx_w[N_W-1:1];
        my   = my_w[N_W-1:1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p4_side_reg <= line_side_reg[SUB_LAT-1];
            if (line_side_reg[SUB_LAT-1].zero) begin
                p4_nx_reg <= '0;
                p4_ny_reg <= '0;
            end else begin
                p4_nx_reg <= line_side_reg[SUB_LAT-1].nx_neg ?
                             -$signed({1'b0, mx}) : $signed({1'b0, mx});
                p4_ny_reg <= line_side_reg[SUB_LAT-1].ny_neg ?
                             -$signed({1'b0, my}) : $signed({1'b0, my});
            end
        end
    end

    // stage 5: corners with saturation
    always_ff @(posedge aclk) begin
        if (en) begin
            p5_c_reg[0].x <= sat_coord(SUM_W'(p4_side_reg.sx) + SUM_W'(p4_nx_reg));
            p5_c_reg[0].y <= sat_coord(SUM_W'(p4_side_reg.sy) + SUM_W'(p4_ny_reg));
            p5_c_reg[1].x <= sat_coord(SUM_W'(p4_side_reg.sx) - SUM_W'(p4_nx_reg));
            p5_c_reg[1].y <= sat_coord(SUM_W'(p4_side_reg.sy) - SUM_W'(p4_ny_reg));
            p5_c_reg[2].x <= sat_coord(SUM_W'(p4_side_reg.ex) + SUM_W'(p4_nx_reg));
            p5_c_reg[2].y <= sat_coord(SUM_W'(p4_side_reg.ey) + SUM_W'(p4_ny_reg));
            p5_c_reg[3].x <= sat_coord(SUM_W'(p4_side_reg.ex) - SUM_W'(p4_nx_reg));
            p5_c_reg[3].y <= sat_coord(SUM_W'(p4_side_reg.ey) - SUM_W'(p4_ny_reg));
        end
    end

    // stage 6: box over corner pairs
    always_ff @(posedge aclk) begin
        if (en) begin
            p6_c_reg      <= p5_c_reg;
            p6_lo01_reg.x <= (p5_c_reg[1].x < p5_c_reg[0].x) ? p5_c_reg[1].x : p5_c_reg[0].x;
            p6_lo01_reg.y <= (p5_c_reg[1].y < p5_c_reg[0].y) ? p5_c_reg[1].y : p5_c_reg[0].y;
            p6_hi01_reg.x <= (p5_c_reg[1].x > p5_c_reg[0].x) ? p5_c_reg[1].x : p5_c_reg[0].x;
            p6_hi01_reg.y <= (p5_c_reg[1].y > p5_c_reg[0].y) ? p5_c_reg[1].y : p5_c_reg[0].y;
            p6_lo23_reg.x <= (p5_c_reg[3].x < p5_c_reg[2].x) ? p5_c_reg[3].x : p5_c_reg[2].x;
            p6_lo23_reg.y <= (p5_c_reg[3].y < p5_c_reg[2].y) ? p5_c_reg[3].y : p5_c_reg[2].y;
            p6_hi23_reg.x <= (p5_c_reg[3].x > p5_c_reg[2].x) ? p5_c_reg[3].x : p5_c_reg[2].x;
            p6_hi23_reg.y <= (p5_c_reg[3].y > p5_c_reg[2].y) ? p5_c_reg[3].y : p5_c_reg[2].y;
        end
    end

    // stage 7: final box and output word
    always_ff @(posedge aclk) begin
        if (en) begin
            out_c_reg    <= p6_c_reg;
            out_lo_reg.x <= (p6_lo23_reg.x < p6_lo01_reg.x) ? p6_lo23_reg.x : p6_lo01_reg.x;
            out_lo_reg.y <= (p6_lo23_reg.y < p6_lo01_reg.y) ? p6_lo23_reg.y : p6_lo01_reg.y;
            out_hi_reg.x <= (p6_hi23_reg.x > p6_hi01_reg.x) ? p6_hi23_reg.x : p6_hi01_reg.x;
            out_hi_reg.y <= (p6_hi23_reg.y > p6_hi01_reg.y) ? p6_hi23_reg.y : p6_hi01_reg.y;
        end
    end

    assign m_tdata = {out_hi_reg.y, out_hi_reg.x, out_lo_reg.y, out_lo_reg.x,
                      out_c_reg[3].y, out_c_reg[3].x, out_c_reg[2].y, out_c_reg[2].x,
                      out_c_reg[1].y, out_c_reg[1].x, out_c_reg[0].y, out_c_reg[0].x};

    // an accepted word always lands in the first stage
    `TLQE_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, p1_v_reg, "accepted word lost")
    // rounded normal stays within +/- N_MAX, half the largest thickness magnitude
    `TLQE_ASSERT_NOW(a_norm_bound, p4_v_reg, (p4_nx_reg <= N_W'(N_MAX)) && (p4_nx_reg >= -N_W'(N_MAX)) && (p4_ny_reg <= N_W'(N_MAX)) && (p4_ny_reg >= -N_W'(N_MAX)), "normal out of range")
    // box is ordered, corner 0 x is at or above box min x and corner 3 y at or below box max y
    `TLQE_ASSERT_NOW(a_box_order, out_v_reg, (out_lo_reg.x <= out_hi_reg.x) && (out_lo_reg.y <= out_hi_reg.y), "box min above max")
    `TLQE_ASSERT_NOW(a_box_holds, out_v_reg, (out_lo_reg.x <= out_c_reg[0].x) && (out_hi_reg.y >= out_c_reg[3].y), "corner outside box")

endmodule
